FILE: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is ignored while the reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Property that is also checked during reset.
`define ASSERT_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: src/maf_pkg.sv
package maf_pkg;

  localparam int unsigned CHANNEL_W = 3;
  localparam int unsigned SAMPLE_W  = 10;

  localparam logic MODE_MEAN = 1'b0;
  localparam logic MODE_TRIM = 1'b1;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;
  } in_word_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel_out;
    logic [SAMPLE_W-1:0]  average;
    logic [SAMPLE_W-1:0]  raw_sample;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic trim;
  } div_ctl_t;

endpackage

FILE: src/multichannel_adc_average_filter_core.sv
// Channel   | Direction | Handshake              | Word
// ----------+-----------+------------------------+-------------------------
// in        | input     | in_valid_i/in_ready_o  | in_word_i  (channel, sample)
// out       | output    | out_valid_o/out_ready_i| out_word_o (channel, average, raw)
// mode      | input     | mode_we_i, no wait     | mode_wdata_i
//
// A word on a configured channel passes the sample write, one ring read per entry,
// the last read data, the trim and divider start, the divider wait, the output load
// and idle; other channels go straight to the output load. After reset a clearing
// pass zeroes the memory, one entry a cycle; no word is taken meanwhile.
// A finished result waits in the output register; the next word is taken while
// it waits, and only a second result stalls behind it.
module multichannel_adc_average_filter_core #(
  parameter int unsigned RING_LENGTH   = 16,
  parameter int unsigned CHANNEL_COUNT = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  maf_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output maf_pkg::out_word_t out_word_o,
  input  logic               mode_we_i,
  input  logic               mode_wdata_i
);

  import maf_pkg::*;

  localparam int unsigned IW    = $clog2(RING_LENGTH);
  localparam int unsigned CIW   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned AW    = CIW + IW;
  localparam int unsigned DEPTH = CHANNEL_COUNT * (2 ** IW);
  localparam int unsigned NW    = $clog2(RING_LENGTH * ((2 ** SAMPLE_W) - 1) + 1);
  localparam logic [CHANNEL_W:0] CH_LIMIT = (CHANNEL_W + 1)'(CHANNEL_COUNT);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DIVST = 3'd5;
  localparam logic [2:0] S_DIVW  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic                 rd_vld_q;
  logic                 first_q;
  logic                 mode_q;
  logic [IW-1:0]        wpos_q [CHANNEL_COUNT];
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_word_q;
  logic [CHANNEL_W-1:0] ch_q;
  logic [SAMPLE_W-1:0]  smp_q;
  logic [SAMPLE_W-1:0]  avg_q;
  logic [NW-1:0]        sum_q;
  logic [SAMPLE_W-1:0]  hi_q, lo_q;

  logic                 accept;
  logic                 ch_ok;
  logic [CIW-1:0]       ch_idx;
  logic [IW-1:0]        pos_cur, pos_next;
  logic                 out_load;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0]  mem_wdata, mem_rdata;

  div_ctl_t             div_ctl;
  logic [NW-1:0]        div_dividend;
  logic                 div_done;
  logic [SAMPLE_W-1:0]  div_quo;

  assign accept   = in_valid_i && in_ready_o;
  assign ch_ok    = ({1'b0, in_word_i.channel} < CH_LIMIT);
  assign ch_idx   = ch_q[CIW-1:0];
  assign pos_cur  = wpos_q[ch_idx];
  assign pos_next = (pos_cur == IW'(RING_LENGTH - 1)) ? '0 : (pos_cur + 1'b1);
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = ch_ok ? S_WRITE : S_OUT;
        end
      end
      S_WRITE: begin
        idx_d   = '0;
        state_d = S_READ;
      end
      S_READ: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == IW'(RING_LENGTH - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_DIVST;
      S_DIVST: state_d = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // The clearing pass and the sample write share the one write port.
  assign mem_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_q : {ch_idx, pos_cur};
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : smp_q;
  assign mem_re    = (state_q == S_READ);
  assign mem_raddr = {ch_idx, idx_q};

  assign div_ctl.start = (state_q == S_DIVST);
  assign div_ctl.trim  = (mode_q == MODE_TRIM);
  assign div_dividend  = div_ctl.trim ? (sum_q - NW'(hi_q) - NW'(lo_q)) : sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      first_q     <= 1'b0;
      mode_q      <= MODE_MEAN;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        wpos_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      idx_q       <= idx_d;
      rd_vld_q    <= mem_re;
      out_valid_q <= out_valid_d;
      if (mode_we_i) begin
        mode_q <= mode_wdata_i;
      end
      if (state_q == S_WRITE) begin
        wpos_q[ch_idx] <= pos_next;
        first_q        <= 1'b1;
      end else if (rd_vld_q) begin
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q  <= in_word_i.channel;
      smp_q <= in_word_i.sample;
      avg_q <= '0;
    end else if ((state_q == S_DIVW) && div_done) begin
      avg_q <= div_quo;
    end
    // Read data lands in the cycle after each ring read is issued.
    if (state_q == S_WRITE) begin
      sum_q <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_q + NW'(mem_rdata);
      if (first_q || (mem_rdata > hi_q)) begin
        hi_q <= mem_rdata;
      end
      if (first_q || (mem_rdata < lo_q)) begin
        lo_q <= mem_rdata;
      end
    end
    if (out_load) begin
      out_word_q.channel_out <= ch_q;
      out_word_q.average     <= avg_q;
      out_word_q.raw_sample  <= smp_q;
    end
  end

  maf_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (SAMPLE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  maf_div #(
    .RING_LENGTH (RING_LENGTH),
    .NW          (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: src/maf_ram.sv
module maf_ram #(
  parameter int unsigned DEPTH = 80,
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/maf_div.sv
module maf_div #(
  parameter int unsigned RING_LENGTH = 16,
  parameter int unsigned NW          = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  maf_pkg::div_ctl_t          ctl_i,
  input  logic [NW-1:0]              dividend_i,
  output logic                       done_o,
  output logic [maf_pkg::SAMPLE_W-1:0] quotient_o
);

  import maf_pkg::*;

  // Division by a constant is a multiply by its rounded-up reciprocal. With the
  // shift set to NW plus the ceiling of log2 of the divisor, the floor is exact for
  // every NW-bit dividend. The dividend is registered into arg_q at start, so the
  // multiply sits between arg_q and quo_q, and done_o comes via go_q and done_q.
  localparam int unsigned     DIV_MEAN = RING_LENGTH;
  localparam int unsigned     DIV_TRIM = RING_LENGTH - 2;
  localparam int unsigned     SH_MEAN  = NW + $clog2(DIV_MEAN);
  localparam int unsigned     SH_TRIM  = NW + $clog2(DIV_TRIM);
  localparam int unsigned     MW       = NW + 1;
  localparam int unsigned     PW       = NW + MW;
  localparam longint unsigned REC_MEAN = ((64'd1 << SH_MEAN) + DIV_MEAN - 1) / DIV_MEAN;
  localparam longint unsigned REC_TRIM = ((64'd1 << SH_TRIM) + DIV_TRIM - 1) / DIV_TRIM;
  localparam logic [MW-1:0]   MUL_MEAN = MW'(REC_MEAN);
  localparam logic [MW-1:0]   MUL_TRIM = MW'(REC_TRIM);

  logic                go_q;
  logic                done_q;
  logic                trim_q;
  logic [NW-1:0]       arg_q;
  logic [SAMPLE_W-1:0] quo_q, quo_d;
  logic [MW-1:0]       mul;
  logic [PW-1:0]       prod;

  assign mul   = trim_q ? MUL_TRIM : MUL_MEAN;
  assign prod  = PW'(arg_q) * PW'(mul);
  assign quo_d = trim_q ? SAMPLE_W'(prod >> SH_TRIM) : SAMPLE_W'(prod >> SH_MEAN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      go_q   <= ctl_i.start;
      done_q <= go_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      arg_q  <= dividend_i;
      trim_q <= ctl_i.trim;
    end
    if (go_q) begin
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: src/maf_checker.sv
`include "assert_macros.svh"

module maf_checker #(
  parameter int unsigned CHANNEL_COUNT = 5
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input maf_pkg::out_word_t out_word_o
);

  import maf_pkg::*;

  localparam logic [CHANNEL_W:0] CH_LIMIT = (CHANNEL_W + 1)'(CHANNEL_COUNT);

  logic in_take;
  logic out_stall;
  logic bad_ch;

  assign in_take   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign bad_ch    = out_valid_o && ({1'b0, out_word_o.channel_out} >= CH_LIMIT);

  // A pending result holds until it is taken.
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_stall |=> (out_valid_o && $stable(out_word_o)))

  // Once a word is taken the block is still busy with it in the following cycle.
  `ASSERT_RST(a_busy_after_accept, clk_i, rst_ni, in_take |=> !in_ready_o)

  // A channel outside the configured range always reports a zero average.
  `ASSERT_RST(a_bad_channel_zero, clk_i, rst_ni, bad_ch |-> (out_word_o.average == '0))

  // No result is shown in the cycle after the reset is seen low.
  `ASSERT_ANY(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind multichannel_adc_average_filter_core maf_checker #(
  .CHANNEL_COUNT (CHANNEL_COUNT)
) u_maf_checker (.*);

FILE: sim/testbench.sv
module testbench;
  import maf_pkg::*;

  localparam int unsigned RING_LEN    = 16;
  localparam int unsigned CH_COUNT    = 5;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_WORDS = 200;
  localparam logic [PHASES-1:0] TRIM_PHASES = 8'b1011_0100;

  logic      clk_i        = 1'b0;
  logic      rst_ni       = 1'b0;
  logic      in_valid_i   = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i    = '0;
  logic      out_valid_o;
  logic      out_ready_i  = 1'b0;
  out_word_t out_word_o;
  logic      mode_we_i    = 1'b0;
  logic      mode_wdata_i = 1'b0;

  multichannel_adc_average_filter_core #(
    .RING_LENGTH  (RING_LEN),
    .CHANNEL_COUNT(CH_COUNT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .mode_we_i   (mode_we_i),
    .mode_wdata_i(mode_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  typedef struct {
    logic         mode;
    in_word_t     word;
    bit           known;
    logic [9:0]   average;
  } plan_row_t;

  plan_row_t   plan[$];
  out_word_t   pending_averages[$];
  int unsigned mismatch_count = 0;
  logic        long_hold_req  = 1'b0;
  logic        quiet_tail     = 1'b0;

  // Shadow copy of the per-channel sample rings.
  logic [9:0]  ring_mem [CH_COUNT][RING_LEN];
  logic [3:0]  ring_wp  [CH_COUNT];
  logic        mode_now;

  function automatic out_word_t predict_average(input in_word_t w);
    out_word_t   r;
    int unsigned ch;
    int unsigned total;
    int unsigned hi;
    int unsigned lo;
    int unsigned v;
    int unsigned k;
    ch            = 32'(w.channel);
    r.channel_out = w.channel;
    r.raw_sample  = w.sample;
    r.average     = '0;
    if (ch < CH_COUNT) begin
      ring_mem[ch][ring_wp[ch]] = w.sample;
      ring_wp[ch] = (32'(ring_wp[ch]) == RING_LEN - 1) ? 4'd0 : ring_wp[ch] + 4'd1;
      total = 0;
      hi    = 32'(ring_mem[ch][0]);
      lo    = hi;
      for (k = 0; k < RING_LEN; k++) begin
        v     = 32'(ring_mem[ch][k]);
        total = total + v;
        if (v > hi) hi = v;
        if (v < lo) lo = v;
      end
      // Trimmed mode drops exactly one largest and one smallest entry, ties included.
      if (mode_now == MODE_TRIM) begin
        r.average = 10'((total - hi - lo) / (RING_LEN - 2));
      end else begin
        r.average = 10'(total / RING_LEN);
      end
    end
    return r;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    if ($urandom_range(0, 9) == 0) begin
      w.channel = 3'($urandom_range(CH_COUNT, 7));
    end else begin
      w.channel = 3'($urandom_range(0, CH_COUNT - 1));
    end
    case ($urandom_range(0, 9)) inside
      5: w.sample = '0;
      6: w.sample = '1;
      // A narrow cluster makes equal largest and smallest entries common.
      [7:8]: w.sample = 10'(512 + $urandom_range(0, 2));
      9: w.sample = ($urandom_range(0, 1) == 1) ? 10'($urandom_range(0, 7))
                                                 : 10'($urandom_range(1016, 1023));
      default: w.sample = 10'($urandom_range(0, 1023));
    endcase
    return w;
  endfunction

  task automatic add_row(input logic m, input int unsigned ch, input int unsigned smp,
                         input bit known, input int unsigned avg);
    plan_row_t row;
    row.mode         = m;
    row.word.channel = 3'(ch);
    row.word.sample  = 10'(smp);
    row.known        = known;
    row.average      = 10'(avg);
    plan.push_back(row);
  endtask

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Valid stays high on return so that the next word can follow without a gap.
  task automatic send_word(input in_word_t w, input bit known, input logic [9:0] avg);
    out_word_t r;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    r = predict_average(w);
    if (known) r.average = avg;
    pending_averages.push_back(r);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain();
    mode_we_i    <= 1'b1;
    mode_wdata_i <= m;
    @(posedge clk_i);
    mode_we_i <= 1'b0;
    mode_now = m;
  endtask

  initial begin : stimulus
    int unsigned p;
    int unsigned n;
    foreach (ring_mem[c, k]) ring_mem[c][k] = '0;
    foreach (ring_wp[c]) ring_wp[c] = '0;
    mode_now = MODE_MEAN;

    add_row(MODE_MEAN, 0, 1023, 1'b1, 63);
    add_row(MODE_MEAN, 0, 0, 1'b1, 63);
    add_row(MODE_MEAN, 1, 0, 1'b1, 0);
    add_row(MODE_MEAN, 4, 1023, 1'b1, 63);
    // Channels past the last one leave the rings alone and report zero.
    add_row(MODE_MEAN, 5, 1023, 1'b1, 0);
    add_row(MODE_MEAN, 7, 0, 1'b1, 0);
    add_row(MODE_MEAN, 6, 555, 1'b1, 0);
    // Fill one ring with full scale; the last word also wraps the write index.
    for (n = 0; n < RING_LEN - 1; n++) add_row(MODE_MEAN, 2, 1023, 1'b0, 0);
    add_row(MODE_MEAN, 2, 1023, 1'b1, 1023);
    // All entries equal, then one low outlier that the trim removes.
    add_row(MODE_TRIM, 2, 1023, 1'b1, 1023);
    add_row(MODE_TRIM, 2, 0, 1'b1, 1023);
    add_row(MODE_TRIM, 0, 1023, 1'b0, 0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].mode !== mode_now) write_mode(plan[i].mode);
      send_word(plan[i].word, plan[i].known, plan[i].average);
    end

    for (p = 0; p < PHASES; p++) begin
      write_mode(TRIM_PHASES[p] ? MODE_TRIM : MODE_MEAN);
      if (p == PHASES - 1) quiet_tail = 1'b1;
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (p == 2 && n == 50) long_hold_req = 1'b1;
        if (p == 4 && n == 100) drain();
        send_word(random_word(), 1'b0, '0);
        // Keep offering words while the output is held off so the input stalls.
        if (!quiet_tail && !(p == 2 && n >= 50 && n < 90) && $urandom_range(0, 5) == 0) begin
          idle_sender($urandom_range(1, 5));
        end
      end
    end

    drain();
    repeat (64) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("multichannel_adc_average_filter_core verification clean");
    end else begin
      $display("multichannel_adc_average_filter_core verification failed");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 5);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_averages.size() == 0) begin
        flag_mismatch("unexpected word, channel", 32'(out_word_o.channel_out), 0);
      end else begin
        want = pending_averages.pop_front();
        if (out_word_o.channel_out !== want.channel_out) begin
          flag_mismatch("channel_out", 32'(out_word_o.channel_out), 32'(want.channel_out));
        end
        if (out_word_o.average !== want.average) begin
          flag_mismatch("average", 32'(out_word_o.average), 32'(want.average));
        end
        if (out_word_o.raw_sample !== want.raw_sample) begin
          flag_mismatch("raw_sample", 32'(out_word_o.raw_sample), 32'(want.raw_sample));
        end
      end
    end
  end

  initial begin : watchdog
    #4000000;
    $display("multichannel_adc_average_filter_core verification failed");
    $finish;
  end

endmodule
